>>> sv/dgp_pkg.sv
// Shared types, fixed-point constants and the CORDIC arctangent table
// for the go-to-point steering block. No dependencies.
package dgp_pkg;

  // Datapath widths
  localparam int TABLE_LEN = 24;
  localparam int VEC_W     = 26;  // vectoring x/y, deltas scaled by 2^8
  localparam int VZ_W      = 29;  // bearing accumulator, radians Q24
  localparam int ROT_W     = 33;  // rotation x/y, Q30
  localparam int RA_W      = 30;  // rotation residual angle, Q24

  // Angle constants in radians Q24
  localparam logic signed [30:0] ANG_PI      = 31'sd52707179;
  localparam logic signed [30:0] ANG_HALF_PI = 31'sd26353590;
  localparam logic signed [30:0] ANG_TWO_PI  = 31'sd105414357;

  // 1/K in Q16, and the rotation start value 1/K in Q30
  localparam logic signed [16:0]      INV_GAIN = 17'sd39797;
  localparam logic signed [ROT_W-1:0] ROT_X0   = 33'sd652034048;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ANG_GAIN  = 3'd0,
    REG_LIN_GAIN  = 3'd1,
    REG_ANG_LIMIT = 3'd2,
    REG_LIN_LIMIT = 3'd3,
    REG_RADIUS    = 3'd4
  } cfg_reg_t;

  // State words of the two cell kinds
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VZ_W-1:0]  z;
  } vec_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [RA_W-1:0]  a;
  } rot_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic [23:0] atan_q24(input int unsigned idx);
    logic [23:0] r;
    case (idx)
      0:  r = 24'd13176795;
      1:  r = 24'd7778716;
      2:  r = 24'd4110060;
      3:  r = 24'd2086331;
      4:  r = 24'd1047214;
      5:  r = 24'd524117;
      6:  r = 24'd262123;
      7:  r = 24'd131069;
      8:  r = 24'd65536;
      9:  r = 24'd32768;
      10: r = 24'd16384;
      11: r = 24'd8192;
      12: r = 24'd4096;
      13: r = 24'd2048;
      14: r = 24'd1024;
      15: r = 24'd512;
      16: r = 24'd256;
      17: r = 24'd128;
      18: r = 24'd64;
      19: r = 24'd32;
      20: r = 24'd16;
      21: r = 24'd8;
      22: r = 24'd4;
      23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/dgp_vec_cell.sv
// One vectoring CORDIC cell: a micro-rotation that drives y toward zero.
// Depends on dgp_pkg for the state word and the arctangent table.
module dgp_vec_cell import dgp_pkg::*; #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  vec_t              din,
  input  logic [SIDE_W-1:0] side_in,
  output vec_t              dout,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic signed [VZ_W-1:0] ATAN = VZ_W'(atan_q24(STAGE));

  vec_t nxt;
  logic signed [VEC_W-1:0] xs, ys;

  // Rotate against the sign of y and track the angle.
  always_comb begin
    xs = din.x >>> STAGE;
    ys = din.y >>> STAGE;
    if (!din.y[VEC_W-1]) begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + ATAN;
    end else begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout     <= nxt;
      side_out <= side_in;
    end
  end

endmodule

>>> sv/dgp_rot_cell.sv
// One rotation CORDIC cell: a micro-rotation that drives the angle toward zero.
// Depends on dgp_pkg for the state word and the arctangent table.
module dgp_rot_cell import dgp_pkg::*; #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 40
) (
  input  logic              clk,
  input  logic              en,
  input  rot_t              din,
  input  logic [SIDE_W-1:0] side_in,
  output rot_t              dout,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic signed [RA_W-1:0] ATAN = RA_W'(atan_q24(STAGE));

  rot_t nxt;
  logic signed [ROT_W-1:0] xs, ys;

  // Rotate with the sign of the residual angle.
  always_comb begin
    xs = din.x >>> STAGE;
    ys = din.y >>> STAGE;
    if (!din.a[RA_W-1]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.a = din.a - ATAN;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.a = din.a + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout     <= nxt;
      side_out <= side_in;
    end
  end

endmodule

>>> sv/differential_drive_goto_point.sv
// Go-to-point steering for a differential-drive robot: top level.
// Depends on dgp_pkg, dgp_vec_cell and dgp_rot_cell.
//
// Usage:
//   The slave stream takes one pose word per handshake: target point, robot
//   position and heading. The master stream returns one word per input with
//   the left and right wheel speed commands, in the same order.
//   The configuration channel writes gains, limits and the robot radius by
//   register index; it is always ready and should be used while idle.
// Timing:
//   Throughput is one word per cycle while the output is not stalled, set by
//   the two CORDIC cell chains (vectoring for bearing and distance, rotation
//   for the cosine of the heading error), each one cell per cycle; each chain
//   has N = min(CORDIC_STAGES, 24) cells.
// Reset:
//   rst clears all valid flags and loads the default gains and limits.
// Stall:
//   The whole pipeline holds while a result sits in the output register and
//   the receiver is not ready; s_tready drops while it holds, nothing is lost.
module differential_drive_goto_point import dgp_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // target_x, target_y, pos_x, pos_y, heading
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // left_speed, right_speed
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int N      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int L      = 2 * N + 7;
  localparam int VS_W   = 16;   // {zero, heading}
  localparam int RS_W   = 40;   // {w_raw, neg, d}

  // Configuration registers
  logic [14:0] ang_gain, lin_gain, ang_limit;
  logic [13:0] lin_limit;
  logic [11:0] radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_gain  <= 15'd6144;
      lin_gain  <= 15'd4096;
      ang_limit <= 15'd12288;
      lin_limit <= 14'd2458;
      radius    <= 12'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ANG_GAIN:  ang_gain  <= cfg_data;
        REG_LIN_GAIN:  lin_gain  <= cfg_data;
        REG_ANG_LIMIT: ang_limit <= cfg_data;
        REG_LIN_LIMIT: lin_limit <= cfg_data[13:0];
        REG_RADIUS:    radius    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Global advance and valid tracking
  logic         en;
  logic [L-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], s_tvalid};
    end
  end

  // Input stage: deltas, half-plane fold for the vectoring chain
  logic signed [14:0] dx, dy;
  logic signed [14:0] head_in;
  vec_t               v_in;
  logic               zero_in;

  always_comb begin
    dx      = $signed({1'b0, s_tdata[13:0]}) - $signed({1'b0, s_tdata[41:28]});
    dy      = $signed({1'b0, s_tdata[27:14]}) - $signed({1'b0, s_tdata[55:42]});
    head_in = $signed(s_tdata[70:56]);
    zero_in = (dx == 15'sd0) && (dy == 15'sd0);
    v_in.x  = $signed({{(VEC_W-23){dx[14]}}, dx, 8'b0});
    v_in.y  = $signed({{(VEC_W-23){dy[14]}}, dy, 8'b0});
    v_in.z  = '0;
    if (dx[14]) begin
      v_in.z = dy[14] ? -VZ_W'(ANG_PI) : VZ_W'(ANG_PI);
      v_in.x = -v_in.x;
      v_in.y = -v_in.y;
    end
  end

  vec_t             vchain [N+1];
  logic [VS_W-1:0]  vside  [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      vchain[0] <= v_in;
      vside[0]  <= {zero_in, head_in};
    end
  end

  // Vectoring cell chain
  for (genvar i = 0; i < N; i++) begin : g_vec
    dgp_vec_cell #(.STAGE(i), .SIDE_W(VS_W)) u_cell (
      .clk      (clk),
      .en       (en),
      .din      (vchain[i]),
      .side_in  (vside[i]),
      .dout     (vchain[i+1]),
      .side_out (vside[i+1])
    );
  end

  // Stage A: heading error with wrap, raw distance product
  logic               zero_n;
  logic signed [14:0] head_n;
  logic signed [VZ_W-1:0]  rho;
  logic signed [VEC_W-1:0] mag;
  logic signed [30:0] err0, err_w;
  logic signed [42:0] mp_next, mp;
  logic signed [27:0] err_a;

  always_comb begin
    zero_n = vside[N][15];
    head_n = $signed(vside[N][14:0]);
    rho    = zero_n ? '0 : vchain[N].z;
    mag    = zero_n ? '0 : vchain[N].x;
    err0   = 31'(rho) - $signed({{4{head_n[14]}}, head_n, 12'b0});
    if (err0 >= ANG_PI) begin
      err_w = err0 - ANG_TWO_PI;
    end else if (err0 < -ANG_PI) begin
      err_w = err0 + ANG_TWO_PI;
    end else begin
      err_w = err0;
    end
    mp_next = mag * INV_GAIN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mp    <= mp_next;
      err_a <= err_w[27:0];
    end
  end

  // Stage B: distance rounding, quadrant fold, angular product
  logic signed [42:0] mp_rnd;
  logic signed [30:0] err_x;
  logic signed [RA_W-1:0] a_fold;
  logic               neg_next;
  logic signed [45:0] wp_next, wp;
  logic signed [17:0] d_b;
  logic signed [RA_W-1:0] a_b;
  logic               neg_b;

  always_comb begin
    mp_rnd = mp + 43'sd8388608;
    err_x  = 31'(err_a);
    if (err_x > ANG_HALF_PI) begin
      a_fold   = RA_W'(err_x - ANG_PI);
      neg_next = 1'b1;
    end else if (err_x < -ANG_HALF_PI) begin
      a_fold   = RA_W'(err_x + ANG_PI);
      neg_next = 1'b1;
    end else begin
      a_fold   = RA_W'(err_x);
      neg_next = 1'b0;
    end
    wp_next = $signed({1'b0, ang_gain}) * err_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_b   <= mp_rnd[41:24];
      a_b   <= a_fold;
      neg_b <= neg_next;
      wp    <= wp_next;
    end
  end

  // Rotation chain entry: start vector and rounded angular speed
  logic signed [45:0] wp_rnd;
  rot_t               r_in;
  rot_t               rchain [N+1];
  logic [RS_W-1:0]    rside  [N+1];

  always_comb begin
    wp_rnd = wp + 46'sd8388608;
    r_in.x = ROT_X0;
    r_in.y = '0;
    r_in.a = a_b;
  end

  assign rchain[0] = r_in;
  assign rside[0]  = {wp_rnd[44:24], neg_b, d_b};

  // Rotation cell chain
  for (genvar i = 0; i < N; i++) begin : g_rot
    dgp_rot_cell #(.STAGE(i), .SIDE_W(RS_W)) u_cell (
      .clk      (clk),
      .en       (en),
      .din      (rchain[i]),
      .side_in  (rside[i]),
      .dout     (rchain[i+1]),
      .side_out (rside[i+1])
    );
  end

  // Stage C: cosine rounding and sign, angular clamp, distance gain
  logic signed [ROT_W-1:0] cx_rnd;
  logic signed [17:0] c_raw;
  logic signed [16:0] c_cl, c_next, c_c;
  logic signed [20:0] w_raw;
  logic signed [20:0] wl21;
  logic signed [15:0] w_next, w_c;
  logic signed [17:0] d_r;
  logic signed [33:0] p1_next, p1;

  always_comb begin
    cx_rnd = rchain[N].x + 33'sd16384;
    c_raw  = cx_rnd[32:15];
    if (c_raw > 18'sd32768) begin
      c_cl = 17'sd32768;
    end else if (c_raw < -18'sd32768) begin
      c_cl = -17'sd32768;
    end else begin
      c_cl = c_raw[16:0];
    end
    c_next = rside[N][18] ? -c_cl : c_cl;
    w_raw  = $signed(rside[N][39:19]);
    wl21   = $signed({6'b0, ang_limit});
    if (w_raw > wl21) begin
      w_next = wl21[15:0];
    end else if (w_raw < -wl21) begin
      w_next = 16'(-wl21);
    end else begin
      w_next = w_raw[15:0];
    end
    d_r     = $signed(rside[N][17:0]);
    p1_next = $signed({1'b0, lin_gain}) * d_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_c <= c_next;
      w_c <= w_next;
      p1  <= p1_next;
    end
  end

  // Stage D: linear speed product and radius term product
  logic signed [50:0] vp;
  logic signed [28:0] rwp;

  always_ff @(posedge clk) begin
    if (en) begin
      vp  <= p1 * c_c;
      rwp <= $signed({1'b0, radius}) * w_c;
    end
  end

  // Stage E: rounding and linear clamp
  logic signed [50:0] vp_rnd;
  logic signed [28:0] rwp_rnd;
  logic signed [23:0] v_raw, vl24;
  logic signed [14:0] v_next, v_e;
  logic signed [16:0] rw_e;

  always_comb begin
    vp_rnd  = vp + 51'sd67108864;
    rwp_rnd = rwp + 29'sd2048;
    v_raw   = vp_rnd[50:27];
    vl24    = $signed({10'b0, lin_limit});
    if (v_raw > vl24) begin
      v_next = vl24[14:0];
    end else if (v_raw < -vl24) begin
      v_next = 15'(-vl24);
    end else begin
      v_next = v_raw[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_e  <= v_next;
      rw_e <= rwp_rnd[28:12];
    end
  end

  // Output stage: wheel speeds, saturated
  logic signed [17:0] l_raw, r_raw;
  logic signed [14:0] l_sat, r_sat;
  logic [31:0]        out_word;

  function automatic logic signed [14:0] sat15(input logic signed [17:0] x);
    logic signed [14:0] r;
    if (x > 18'sd16383) begin
      r = 15'sd16383;
    end else if (x < -18'sd16384) begin
      r = -15'sd16384;
    end else begin
      r = x[14:0];
    end
    return r;
  endfunction

  always_comb begin
    l_raw = 18'(v_e) - 18'(rw_e);
    r_raw = 18'(v_e) + 18'(rw_e);
    l_sat = sat15(l_raw);
    r_sat = sat15(r_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= {2'b0, r_sat, l_sat};
    end
  end

  assign m_tdata = out_word;

endmodule

>>> sv/dgp_checker.sv
// Port-level checks for the go-to-point steering block, bound to the top level.
// Depends only on the top level's ports.
module dgp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_ready
);

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // Nothing comes out in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // With an empty output register the block must take input.
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // While a word is valid, its unused bits are zero and configuration is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:30] == 2'b00 && cfg_ready)
    else $error("padding bits set or config not ready");

endmodule

bind differential_drive_goto_point dgp_checker u_dgp_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);
